>>> hw/rtl/mdfs_pkg.sv
// Shared types and constants for the maze depth-first path finder.
`timescale 1ns / 1ps

package mdfs_pkg;

   // Largest number of path beats one search may emit; also caps the stack
   localparam int MAX_RESULTS = 64;

   // Widths of the coordinate and direction fields on the result channel
   localparam int COORD_W = 4;
   localparam int DIR_W   = 2;

   // Step directions, in the order the walk tries them
   typedef enum logic [DIR_W-1:0] {
      DIR_RIGHT = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_UP    = 2'd3
   } dir_type;

   // Request command codes
   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_SEARCH = 1'b1
   } req_cmd_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clear_step;  // write one cell of the power-up clearing pass
      logic load_cell;   // write one cell from the request beat
      logic start;       // begin a search at the top-left cell
      logic dir_next;    // current direction is blocked, try the next one
      logic probe_rd;    // read the neighbor cell
      logic push;        // push the walk position and step into the neighbor
      logic pop_rd;      // read the top of stack and drop it
      logic pop_ld;      // resume the walk from the popped entry
      logic emit_rd;     // read the next stack entry for output
      logic emit_out;    // load a path beat into the output register
      logic fail_out;    // load the no-path beat into the output register
   } mdfs_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_done;
      logic rsp_free;
      logic dir_done;
      logic nbr_out;
      logic blocked;
      logic stack_empty;
      logic stack_full;
      logic at_target;
      logic emit_last;
   } mdfs_status_type;

endpackage

>>> hw/rtl/mdfs_if.sv
// Valid/ready channel interfaces for request and response beats.
`timescale 1ns / 1ps

interface mdfs_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [3:0] cell_row;
   logic [3:0] cell_col;
   logic       is_wall;

   modport source (output valid, output cmd, output cell_row, output cell_col,
                   output is_wall, input ready);
   modport sink   (input valid, input cmd, input cell_row, input cell_col,
                   input is_wall, output ready);
endinterface

interface mdfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] path_row;
   logic [3:0] path_col;
   logic [1:0] step_dir;
   logic       found;
   logic       last;

   modport source (output valid, output path_row, output path_col, output step_dir,
                   output found, output last, input ready);
   modport sink   (input valid, input path_row, input path_col, input step_dir,
                   input found, input last, output ready);
endinterface

>>> hw/rtl/mdfs_datapath.sv
// Datapath: cell memories, walk registers, path stack and response register.
`timescale 1ns / 1ps

module mdfs_datapath #(
   parameter int ROWS        = 8,
   parameter int COLS        = 8,
   parameter int STACK_DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mdfs_pkg::mdfs_cmd_type    dp_cmd,
   output mdfs_pkg::mdfs_status_type dp_status,
   input  logic [3:0]                req_cell_row,
   input  logic [3:0]                req_cell_col,
   input  logic                      req_is_wall,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [3:0]                rsp_path_row,
   output logic [3:0]                rsp_path_col,
   output logic [1:0]                rsp_step_dir,
   output logic                      rsp_found,
   output logic                      rsp_last
);

   localparam int CELLS     = ROWS * COLS;
   localparam int CAW       = $clog2(CELLS);
   localparam int RW        = $clog2(ROWS + 2);
   localparam int CLW       = $clog2(COLS + 2);
   localparam int STACK_CAP = (STACK_DEPTH < mdfs_pkg::MAX_RESULTS) ?
                              STACK_DEPTH : mdfs_pkg::MAX_RESULTS;
   localparam int SAW       = $clog2(STACK_CAP);
   localparam int CNTW      = $clog2(STACK_CAP + 1);

   typedef struct packed {
      logic [RW-1:0]              row;
      logic [CLW-1:0]             col;
      logic [mdfs_pkg::DIR_W-1:0] dir;
   } stk_entry_type;

   // Cell memories: wall bit and visited bit share addressing
   logic           wall_mem_ff [CELLS];
   logic           seen_mem_ff [CELLS];
   logic           wall_rd_ff;
   logic           seen_rd_ff;

   // Path stack
   stk_entry_type  stk_mem_ff [STACK_CAP];
   stk_entry_type  stk_rd_ff;

   // Control registers
   logic [CAW-1:0]  clr_idx_ff;
   logic [RW-1:0]   walk_row_ff;
   logic [CLW-1:0]  walk_col_ff;
   logic [2:0]      walk_dir_ff;
   logic [CNTW-1:0] count_ff;
   logic [SAW-1:0]  emit_idx_ff;
   logic            rsp_valid_ff;

   // Response payload registers
   logic [3:0] path_row_ff;
   logic [3:0] path_col_ff;
   logic [1:0] step_dir_ff;
   logic       found_ff;
   logic       last_ff;

   // Neighbor of the walk position in the current direction
   logic [RW-1:0]  nbr_row;
   logic [CLW-1:0] nbr_col;
   logic [CAW-1:0] nbr_addr;
   logic           nbr_out;

   always_comb begin
      nbr_row = walk_row_ff;
      nbr_col = walk_col_ff;
      unique case (mdfs_pkg::dir_type'(walk_dir_ff[1:0]))
         mdfs_pkg::DIR_RIGHT: nbr_col = CLW'(walk_col_ff + 1'b1);
         mdfs_pkg::DIR_DOWN:  nbr_row = RW'(walk_row_ff + 1'b1);
         mdfs_pkg::DIR_LEFT:  nbr_col = CLW'(walk_col_ff - 1'b1);
         mdfs_pkg::DIR_UP:    nbr_row = RW'(walk_row_ff - 1'b1);
      endcase
   end

   assign nbr_out  = (nbr_row == '0) || (nbr_row > RW'(ROWS)) ||
                     (nbr_col == '0) || (nbr_col > CLW'(COLS));
   assign nbr_addr = CAW'((int'(nbr_row) - 1) * COLS + int'(nbr_col) - 1);

   // Load address and range check of the request beat
   logic           load_ok;
   logic [CAW-1:0] load_addr;

   assign load_ok   = (req_cell_row != '0) && (int'(req_cell_row) <= ROWS) &&
                      (req_cell_col != '0) && (int'(req_cell_col) <= COLS);
   assign load_addr = CAW'((int'(req_cell_row) - 1) * COLS + int'(req_cell_col) - 1);

   // Cell write port selection
   logic [CAW-1:0] wr_addr;
   logic           wall_we;
   logic           seen_we;
   logic           wall_wd;
   logic           seen_wd;

   always_comb begin
      wr_addr = '0;
      wall_we = 1'b0;
      seen_we = 1'b0;
      wall_wd = 1'b0;
      seen_wd = 1'b0;
      if (dp_cmd.clear_step) begin
         wr_addr = clr_idx_ff;
         wall_we = 1'b1;
         seen_we = 1'b1;
      end else if (dp_cmd.load_cell && load_ok) begin
         wr_addr = load_addr;
         wall_we = 1'b1;
         seen_we = 1'b1;
         wall_wd = req_is_wall;
      end else if (dp_cmd.start) begin
         // start cell is marked even when it is a wall
         seen_we = 1'b1;
         seen_wd = 1'b1;
      end else if (dp_cmd.push) begin
         wr_addr = nbr_addr;
         seen_we = 1'b1;
         seen_wd = 1'b1;
      end
   end

   // Cell memories, registered read of the neighbor
   always_ff @(posedge clock) begin
      if (wall_we) begin
         wall_mem_ff[wr_addr] <= wall_wd;
      end
      if (seen_we) begin
         seen_mem_ff[wr_addr] <= seen_wd;
      end
      if (dp_cmd.probe_rd) begin
         wall_rd_ff <= wall_mem_ff[nbr_addr];
         seen_rd_ff <= seen_mem_ff[nbr_addr];
      end
   end

   // Path stack, one write and one registered read port
   logic [SAW-1:0] stk_rd_addr;

   assign stk_rd_addr = dp_cmd.pop_rd ? SAW'(count_ff - 1'b1) : emit_idx_ff;

   always_ff @(posedge clock) begin
      if (dp_cmd.push) begin
         stk_mem_ff[count_ff[SAW-1:0]] <= '{row: walk_row_ff, col: walk_col_ff,
                                            dir: walk_dir_ff[1:0]};
      end
      if (dp_cmd.pop_rd || dp_cmd.emit_rd) begin
         stk_rd_ff <= stk_mem_ff[stk_rd_addr];
      end
   end

   logic emit_last;

   assign emit_last = (int'(emit_idx_ff) + 1) == int'(count_ff);

   // Walk position, stack count and sweep counters
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff   <= '0;
         walk_row_ff  <= '0;
         walk_col_ff  <= '0;
         walk_dir_ff  <= '0;
         count_ff     <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (dp_cmd.clear_step) begin
            clr_idx_ff <= CAW'(clr_idx_ff + 1'b1);
         end

         if (dp_cmd.start) begin
            walk_row_ff <= RW'(1);
            walk_col_ff <= CLW'(1);
            walk_dir_ff <= '0;
         end else if (dp_cmd.push) begin
            walk_row_ff <= nbr_row;
            walk_col_ff <= nbr_col;
            walk_dir_ff <= '0;
         end else if (dp_cmd.dir_next) begin
            walk_dir_ff <= walk_dir_ff + 3'd1;
         end else if (dp_cmd.pop_ld) begin
            walk_row_ff <= stk_rd_ff.row;
            walk_col_ff <= stk_rd_ff.col;
            walk_dir_ff <= {1'b0, stk_rd_ff.dir} + 3'd1;
         end

         if (dp_cmd.start || dp_cmd.fail_out ||
             (dp_cmd.emit_out && emit_last)) begin
            count_ff <= '0;
         end else if (dp_cmd.push) begin
            count_ff <= count_ff + 1'b1;
         end else if (dp_cmd.pop_rd) begin
            count_ff <= count_ff - 1'b1;
         end

         if (dp_cmd.start) begin
            emit_idx_ff <= '0;
         end else if (dp_cmd.emit_out) begin
            emit_idx_ff <= SAW'(emit_idx_ff + 1'b1);
         end

         if (dp_cmd.emit_out || dp_cmd.fail_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (dp_cmd.fail_out) begin
         path_row_ff <= '0;
         path_col_ff <= '0;
         step_dir_ff <= '0;
         found_ff    <= 1'b0;
         last_ff     <= 1'b1;
      end else if (dp_cmd.emit_out) begin
         path_row_ff <= mdfs_pkg::COORD_W'(stk_rd_ff.row);
         path_col_ff <= mdfs_pkg::COORD_W'(stk_rd_ff.col);
         step_dir_ff <= stk_rd_ff.dir;
         found_ff    <= 1'b1;
         last_ff     <= emit_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_path_row = path_row_ff;
   assign rsp_path_col = path_col_ff;
   assign rsp_step_dir = step_dir_ff;
   assign rsp_found    = found_ff;
   assign rsp_last     = last_ff;

   // Status back to the controller
   assign dp_status.clear_done  = clr_idx_ff == CAW'(CELLS - 1);
   assign dp_status.rsp_free    = !rsp_valid_ff || rsp_ready;
   assign dp_status.dir_done    = walk_dir_ff[2];
   assign dp_status.nbr_out     = nbr_out;
   assign dp_status.blocked     = wall_rd_ff || seen_rd_ff;
   assign dp_status.stack_empty = count_ff == '0;
   assign dp_status.stack_full  = count_ff == CNTW'(STACK_CAP);
   assign dp_status.at_target   = (nbr_row == RW'(ROWS)) && (nbr_col == CLW'(COLS));
   assign dp_status.emit_last   = emit_last;

`ifndef NO_ASSERTIONS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= STACK_CAP)
      else $error("stack count beyond capacity");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.push |-> (count_ff != CNTW'(STACK_CAP)))
      else $error("push into a full stack");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.pop_rd |-> (count_ff != '0))
      else $error("pop from an empty stack");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.emit_out || dp_cmd.fail_out) |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten");

   a_fail_beat: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.fail_out |=> (rsp_valid_ff && !found_ff && last_ff))
      else $error("no-path beat malformed");
`endif

endmodule

>>> hw/rtl/mdfs_ctrl.sv
// Controller: sequences clearing, loads, the depth-first walk and emission.
`timescale 1ns / 1ps

module mdfs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_cmd,
   output logic                      req_ready,
   input  mdfs_pkg::mdfs_status_type dp_status,
   output mdfs_pkg::mdfs_cmd_type    dp_cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_PROBE_CHK,
      ST_POP_LD,
      ST_FAIL,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            dp_cmd.clear_step = 1'b1;
            if (dp_status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == mdfs_pkg::CMD_SEARCH) begin
                  dp_cmd.start = 1'b1;
                  state_in     = ST_PROBE;
               end else begin
                  dp_cmd.load_cell = 1'b1;
               end
            end
         end
         ST_PROBE: begin
            priority if (dp_status.dir_done) begin
               // all directions tried: backtrack or give up
               if (dp_status.stack_empty) begin
                  state_in = ST_FAIL;
               end else begin
                  dp_cmd.pop_rd = 1'b1;
                  state_in      = ST_POP_LD;
               end
            end else if (dp_status.nbr_out) begin
               dp_cmd.dir_next = 1'b1;
            end else begin
               dp_cmd.probe_rd = 1'b1;
               state_in        = ST_PROBE_CHK;
            end
         end
         ST_PROBE_CHK: begin
            priority if (dp_status.blocked) begin
               dp_cmd.dir_next = 1'b1;
               state_in        = ST_PROBE;
            end else if (dp_status.stack_full) begin
               state_in = ST_FAIL;
            end else begin
               dp_cmd.push = 1'b1;
               state_in    = dp_status.at_target ? ST_EMIT_RD : ST_PROBE;
            end
         end
         ST_POP_LD: begin
            dp_cmd.pop_ld = 1'b1;
            state_in      = ST_PROBE;
         end
         ST_FAIL: begin
            if (dp_status.rsp_free) begin
               dp_cmd.fail_out = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            dp_cmd.emit_rd = 1'b1;
            state_in       = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (dp_status.rsp_free) begin
               dp_cmd.emit_out = 1'b1;
               state_in        = dp_status.emit_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;

`ifndef NO_ASSERTIONS
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.load_cell || dp_cmd.start) |-> req_ready)
      else $error("request acted on while busy");

   a_start_walk: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.start |=> (state_ff == ST_PROBE) && !req_ready)
      else $error("search did not enter the walk");

   a_chk_after_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE_CHK) |-> $past(dp_cmd.probe_rd))
      else $error("neighbor checked without a read");
`endif

endmodule

>>> hw/rtl/maze_dfs_path_finder.sv
// Top level of the maze depth-first path finder.
`timescale 1ns / 1ps

//  Channel  | Dir | Handshake           | Beat contents
//  ---------+-----+---------------------+------------------------------------------
//  req_bus  | in  | valid/ready         | cmd, cell_row, cell_col, is_wall
//  rsp_bus  | out | valid/ready         | path_row, path_col, step_dir, found, last
//
//  After reset a clearing pass over the ROWS*COLS cells holds req_bus.ready low.
//  Loads stream at one per cycle. Search: an in-grid probe runs ST_PROBE, then
//  ST_PROBE_CHK; a backtrack ST_PROBE, ST_POP_LD; a border probe ST_PROBE only.
//  Emission: ST_EMIT_RD then ST_EMIT_LD per beat, held there while rsp_bus stalls.
//  Requests are held off from the search beat until the last result is loaded;
//  the output register then frees the request side even if rsp_bus stalls.

module maze_dfs_path_finder #(
   parameter int ROWS        = 8,
   parameter int COLS        = 8,
   parameter int STACK_DEPTH = 64
) (
   input logic        clock,
   input logic        reset,
   mdfs_req_if.sink   req_bus,
   mdfs_rsp_if.source rsp_bus
);

   mdfs_pkg::mdfs_cmd_type    dp_cmd;
   mdfs_pkg::mdfs_status_type dp_status;

   // Sequencer
   mdfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_cmd   (req_bus.cmd),
      .req_ready (req_bus.ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // Memories, walk state and response register
   mdfs_datapath #(
      .ROWS        (ROWS),
      .COLS        (COLS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .dp_cmd       (dp_cmd),
      .dp_status    (dp_status),
      .req_cell_row (req_bus.cell_row),
      .req_cell_col (req_bus.cell_col),
      .req_is_wall  (req_bus.is_wall),
      .rsp_ready    (rsp_bus.ready),
      .rsp_valid    (rsp_bus.valid),
      .rsp_path_row (rsp_bus.path_row),
      .rsp_path_col (rsp_bus.path_col),
      .rsp_step_dir (rsp_bus.step_dir),
      .rsp_found    (rsp_bus.found),
      .rsp_last     (rsp_bus.last)
   );

endmodule
